// ===== rtl/che_pkg.sv =====
`default_nettype none
package che_pkg;

	localparam int SYMBOLS_DEF = 256;
	localparam int MAX_LEN     = 15;
	localparam int LEN_W       = 4;
	localparam int CODE_W      = 15;
	localparam int ACC_W       = 16;
	localparam int LEN_TOP     = 15;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_BUILD,
		CMD_ENCODE,
		CMD_FLUSH
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENC,
		ST_BUILD,
		ST_DRAIN,
		ST_EMIT0,
		ST_EMIT1
	} state_t;

	typedef struct packed {
		logic ld_we;
		logic bld_start;
		logic bld_step;
		logic enc_commit;
		logic flush_commit;
		logic sel_b1;
	} dp_cmd_t;

	typedef struct packed {
		logic bld_end;
		logic pend_nz;
		logic enc_nz;
		logic two_q;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/che_if.sv =====
`default_nettype none
interface che_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] symbol;
	logic [3:0] code_length;

	modport source (output valid, command, symbol, code_length, input ready);
	modport sink (input valid, command, symbol, code_length, output ready);
endinterface

interface che_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, out_byte, last, input ready);
	modport sink (input valid, out_byte, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/che_ctrl.sv =====
`default_nettype none
module che_ctrl
	import che_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire cmd_t    in_command,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	state_t st_q, st_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	always_comb begin
		st_nxt    = st_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_command)
						CMD_LOAD: begin
							cmd.ld_we = 1'b1;
						end
						CMD_BUILD: begin
							cmd.bld_start = 1'b1;
							st_nxt = ST_BUILD;
						end
						CMD_ENCODE: begin
							st_nxt = ST_ENC;
						end
						CMD_FLUSH: begin
							cmd.flush_commit = 1'b1;
							if (sts.pend_nz) st_nxt = ST_EMIT0;
						end
						default: st_nxt = ST_IDLE;
					endcase
				end
			end
			ST_ENC: begin
				cmd.enc_commit = 1'b1;
				st_nxt = sts.enc_nz ? ST_EMIT0 : ST_IDLE;
			end
			ST_BUILD: begin
				cmd.bld_step = 1'b1;
				if (sts.bld_end) st_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last length read of the walk retires here
				st_nxt = ST_IDLE;
			end
			ST_EMIT0: begin
				out_valid = 1'b1;
				if (out_ready) st_nxt = sts.two_q ? ST_EMIT1 : ST_IDLE;
			end
			ST_EMIT1: begin
				out_valid  = 1'b1;
				cmd.sel_b1 = 1'b1;
				if (out_ready) st_nxt = ST_IDLE;
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input and output active together");

	a_second_byte: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_EMIT1 |-> ($past(st_q) == ST_EMIT0 || $past(st_q) == ST_EMIT1))
		else $error("second byte without first");

	a_enc_exit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_ENC |=> (st_q == ST_IDLE || st_q == ST_EMIT0))
		else $error("encode step left to wrong state");

endmodule
`default_nettype wire

// ===== rtl/che_dp.sv =====
`default_nettype none
module che_dp
	import che_pkg::*;
#(
	parameter int SYMBOLS = SYMBOLS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dp_cmd_t          cmd,
	output dp_sts_t               sts,
	input  wire logic [7:0]       in_symbol,
	input  wire logic [LEN_W-1:0] in_code_length,
	output logic [7:0]            out_byte,
	output logic                  out_last
);

	localparam int AW = $clog2(SYMBOLS);

	logic [LEN_W-1:0]  len_mem [SYMBOLS];
	logic [CODE_W-1:0] code_mem [SYMBOLS];
	logic [SYMBOLS-1:0] vld_q;

	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [LEN_W-1:0]  len_rd_q;
	logic [CODE_W-1:0] code_rd_q;
	logic              vld_rd_q;
	logic [LEN_W-1:0]  len_rd;
	logic              sym_in_ok;
	logic              sym_ok_q;
	logic [LEN_W-1:0]  len_sat;

	// build walk
	logic [AW-1:0]    bld_s_q;
	logic [LEN_W-1:0] bld_len_q;
	logic             bld_v_s1;
	logic [AW-1:0]    bld_s_s1;
	logic [LEN_W-1:0] bld_len_s1;
	logic             first_q;
	logic [LEN_W-1:0] prev_len_q;
	logic [ACC_W-1:0] code_q;
	logic [LEN_W-1:0] len_diff;
	logic [ACC_W-1:0] code_sh;
	logic [ACC_W-1:0] code_mask;
	logic [ACC_W-1:0] code_msk;
	logic             match;
	logic             code_we;
	logic [CODE_W-1:0] code_wd;

	// byte packer
	logic [7:0]        pend_q;
	logic [2:0]        pend_cnt_q;
	logic [7:0]        b0_q;
	logic [7:0]        b1_q;
	logic              two_q;
	logic [LEN_W-1:0]  eff_len;
	logic [CODE_W-1:0] sel_mask;
	logic [CODE_W-1:0] code_bits;
	logic [4:0]        total;
	logic [4:0]        sh;
	logic [23:0]       win;
	logic [7:0]        pend_nxt;

	assign sym_in_ok = {1'b0, in_symbol} < 9'(SYMBOLS);
	assign wr_addr   = in_symbol[AW-1:0];
	assign rd_addr   = cmd.bld_step ? bld_s_q : in_symbol[AW-1:0];
	assign len_sat   = ({1'b0, in_code_length} > 5'(MAX_LEN)) ? LEN_W'(MAX_LEN)
	                                                          : in_code_length;
	assign len_rd    = vld_rd_q ? len_rd_q : '0;

	// code assignment for the entry read in the previous cycle
	assign match     = (len_rd == bld_len_s1);
	assign len_diff  = bld_len_s1 - prev_len_q;
	assign code_sh   = (!first_q && (bld_len_s1 > prev_len_q)) ? (code_q << len_diff) : code_q;
	assign code_mask = (ACC_W'(1) << bld_len_s1) - ACC_W'(1);
	assign code_msk  = code_sh & code_mask;
	// first pass rewrites every entry, unused ones get zero
	assign code_we   = bld_v_s1 && (match || (bld_len_s1 == LEN_W'(1)));
	assign code_wd   = match ? code_msk[CODE_W-1:0] : '0;

	assign eff_len   = sym_ok_q ? len_rd : '0;
	assign sel_mask  = (CODE_W'(1) << eff_len) - CODE_W'(1);
	assign code_bits = code_rd_q & sel_mask;
	assign total     = {2'b00, pend_cnt_q} + {1'b0, eff_len};
	assign sh        = 5'd24 - total;
	assign win       = {pend_q, 16'h0000} | ({9'b0, code_bits} << sh);

	always_comb begin
		case (total[4:3])
			2'd0:    pend_nxt = win[23:16];
			2'd1:    pend_nxt = win[15:8];
			default: pend_nxt = win[7:0];
		endcase
	end

	always_ff @(posedge clk) begin
		len_rd_q  <= len_mem[rd_addr];
		code_rd_q <= code_mem[rd_addr];
		vld_rd_q  <= vld_q[rd_addr];
		if (cmd.ld_we && sym_in_ok) len_mem[wr_addr] <= len_sat;
		if (code_we) code_mem[bld_s_s1] <= code_wd;
	end

	always_ff @(posedge clk) begin
		sym_ok_q   <= sym_in_ok;
		bld_s_s1   <= bld_s_q;
		bld_len_s1 <= bld_len_q;
		if (cmd.enc_commit) begin
			b0_q <= win[23:16];
			b1_q <= win[15:8];
		end else if (cmd.flush_commit) begin
			b0_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			bld_v_s1   <= 1'b0;
			bld_s_q    <= '0;
			bld_len_q  <= '0;
			first_q    <= 1'b1;
			prev_len_q <= '0;
			code_q     <= '0;
			pend_q     <= '0;
			pend_cnt_q <= '0;
			two_q      <= 1'b0;
		end else begin
			bld_v_s1 <= cmd.bld_step;
			if (cmd.ld_we && sym_in_ok) vld_q[wr_addr] <= 1'b1;
			if (cmd.bld_start) begin
				bld_s_q    <= '0;
				bld_len_q  <= LEN_W'(1);
				first_q    <= 1'b1;
				prev_len_q <= '0;
				code_q     <= '0;
			end else begin
				if (cmd.bld_step) begin
					if (bld_s_q == AW'(SYMBOLS - 1)) begin
						bld_s_q   <= '0;
						bld_len_q <= bld_len_q + LEN_W'(1);
					end else begin
						bld_s_q <= bld_s_q + AW'(1);
					end
				end
				if (bld_v_s1 && match) begin
					first_q    <= 1'b0;
					prev_len_q <= bld_len_s1;
					code_q     <= code_sh + ACC_W'(1);
				end
			end
			if (cmd.enc_commit) begin
				pend_q     <= pend_nxt;
				pend_cnt_q <= total[2:0];
				two_q      <= total[4];
			end else if (cmd.flush_commit) begin
				pend_q     <= '0;
				pend_cnt_q <= '0;
				two_q      <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.bld_end = (bld_s_q == AW'(SYMBOLS - 1)) && (bld_len_q == LEN_W'(LEN_TOP));
		sts.pend_nz = |pend_cnt_q;
		sts.enc_nz  = |total[4:3];
		sts.two_q   = two_q;
	end

	assign out_byte = cmd.sel_b1 ? b1_q : b0_q;
	assign out_last = cmd.sel_b1 | ~two_q;

	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		bld_v_s1 |-> bld_len_s1 != '0)
		else $error("build walk on length zero");

	a_pack_idle_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.enc_commit || cmd.flush_commit) |-> !bld_v_s1)
		else $error("packer update during build walk");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush_commit |=> (pend_cnt_q == '0 && pend_q == '0))
		else $error("flush left pending bits");

endmodule
`default_nettype wire

// ===== rtl/canonical_huffman_encoder.sv =====
// load: stores one length; encode: length and code read, then pack, then emit each full byte
// flush: emits the partial byte if any bits are pending
// build: one pass per length from 1 to 15 over all SYMBOLS entries, one length-store read per cycle
// one request in flight; a new request is taken once all its bytes have been taken
// arst_n clears the length store valid bits, packer and controller; code store holds
// garbage until the first build
`default_nettype none
module canonical_huffman_encoder
	import che_pkg::*;
#(
	parameter int SYMBOLS = SYMBOLS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	che_in_if.sink    in_ch,
	che_out_if.source out_ch
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	che_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (cmd_t'(in_ch.command)),
		.in_ready   (in_ch.ready),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	che_dp #(
		.SYMBOLS (SYMBOLS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_symbol      (in_ch.symbol),
		.in_code_length (in_ch.code_length),
		.out_byte       (out_ch.out_byte),
		.out_last       (out_ch.last)
	);

endmodule
`default_nettype wire
